### sv/prcs_pkg.sv
// Shared types, constants and helpers for the periodic radial cumulative sum block.
// Used by periodic_radial_cumulative_sum; depends on nothing else.
package prcs_pkg;

	// default sizing
	localparam int MAX_BINS_DEF   = 64;
	localparam int COORD_BITS_DEF = 8;

	// fixed field widths
	localparam int EXT_W    = 9;
	localparam int RADIUS_W = 6;
	localparam int SAMPLE_W = 32;
	localparam int SUM_W    = 64;
	localparam int DIV_W    = 10;
	localparam int AXIS_SQ_W = 17;
	localparam int NSQ_W    = 19;

	// apb map
	localparam int APB_ADDR_W = 5;
	localparam int APB_DATA_W = 32;

	// register indexes
	localparam logic [2:0] REG_EXTENT_T   = 3'd0;
	localparam logic [2:0] REG_EXTENT_X   = 3'd1;
	localparam logic [2:0] REG_EXTENT_Y   = 3'd2;
	localparam logic [2:0] REG_EXTENT_Z   = 3'd3;
	localparam logic [2:0] REG_MODE_3D    = 3'd4;
	localparam logic [2:0] REG_MAX_RADIUS = 3'd5;

	// axis codes
	localparam logic [1:0] AXIS_T = 2'd0;
	localparam logic [1:0] AXIS_X = 2'd1;
	localparam logic [1:0] AXIS_Y = 2'd2;
	localparam logic [1:0] AXIS_Z = 2'd3;

	// register reset values
	localparam logic [EXT_W-1:0]    EXTENT_RST     = 9'd16;
	localparam logic [RADIUS_W-1:0] MAX_RADIUS_RST = 6'd8;

	// signed 64-bit add of a sign-extended sample, clamped at the limits
	function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] acc,
		input logic [SAMPLE_W-1:0] val);
		logic [SUM_W:0] sum;
		sum = {acc[SUM_W-1], acc} + {{(SUM_W-SAMPLE_W+1){val[SAMPLE_W-1]}}, val};
		if (sum[SUM_W] != sum[SUM_W-1]) begin
			sat_add = sum[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
		end else begin
			sat_add = sum[SUM_W-1:0];
		end
	endfunction

endpackage

### sv/periodic_radial_cumulative_sum.sv
// Top level of the periodic radial cumulative sum block: sequencer, remainder unit,
// bin memory with valid bits, apb register file. Depends on prcs_pkg.
//
// Usage:
//   The s_ channel takes one lattice point per item (coordinates, Q16.16 sample,
//   tlast marks the final point). The block works out the periodic minimum-image
//   squared norm and adds the sample, saturating, into every bin whose d*d is at
//   or above the norm. On a point with tlast it sends max_radius+1 items on the
//   m_ channel (radius, cumulative sum; tlast on the last radius) and clears bins.
//   Steps per point: each counted axis runs a one-bit restoring remainder step
//   for each coordinate bit, then a fold-and-square step (four axes, three in
//   3d mode); then the bin sweep does one read-modify-write per bin over all
//   MAX_BINS bins on separate read and write ports, then a drain state, then
//   the idle state for acceptance. Each emitted result is a bin read and then
//   a load of the output register; a stalled receiver holds the output
//   register and the emit waits for it. The next point is accepted while the
//   final result still waits in the output register.
//   Reset clears the registers to their defaults and the bin valid bits, so all
//   bins read as zero; no clearing pass is needed. s_tready is high only in idle.
//   The apb port has pready tied high; configure only while the block is idle.
module periodic_radial_cumulative_sum #(
	parameter int MAX_BINS   = prcs_pkg::MAX_BINS_DEF,
	parameter int COORD_BITS = prcs_pkg::COORD_BITS_DEF,
	localparam int IN_DATA_W  = ((4*COORD_BITS + prcs_pkg::SAMPLE_W + 7) / 8) * 8,
	localparam int OUT_DATA_W = ((prcs_pkg::RADIUS_W + prcs_pkg::SUM_W + 7) / 8) * 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// apb configuration port
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [prcs_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [prcs_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [prcs_pkg::APB_DATA_W-1:0]   prdata,
	output logic                              pready,
	// input item stream
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [IN_DATA_W-1:0]              s_tdata, // coord_t, coord_x, coord_y, coord_z, sample_value
	input  logic                              s_tlast, // last_item
	// result item stream
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [OUT_DATA_W-1:0]             m_tdata, // radius, cumulative_sum
	output logic                              m_tlast  // last_bin
);

	localparam int BIN_W  = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
	localparam int CB_IDX = (COORD_BITS > 1) ? $clog2(COORD_BITS) : 1;
	localparam logic [BIN_W-1:0]  BIN_LAST = BIN_W'(MAX_BINS - 1);
	localparam logic [CB_IDX-1:0] BIT_TOP  = CB_IDX'(COORD_BITS - 1);
	localparam logic [prcs_pkg::RADIUS_W:0] TOP_LIMIT = (prcs_pkg::RADIUS_W + 1)'(MAX_BINS - 1);
	localparam logic [prcs_pkg::DIV_W-1:0]  EXT_ZERO_N = prcs_pkg::DIV_W'(512);

	typedef enum logic [2:0] {
		S_IDLE, S_DIV, S_FOLD, S_SWEEP, S_DRAIN, S_EMIT_RD, S_EMIT_OUT
	} state_t;

	// configuration registers
	logic [prcs_pkg::EXT_W-1:0]    extent_t_q, extent_x_q, extent_y_q, extent_z_q;
	logic                          mode_3d_q;
	logic [prcs_pkg::RADIUS_W-1:0] max_radius_q;

	// sequencer and datapath registers
	state_t                          state_q;
	logic [1:0]                      axis_q;
	logic [CB_IDX-1:0]               bit_q;
	logic [prcs_pkg::DIV_W-1:0]      rem_q;
	logic [prcs_pkg::NSQ_W-1:0]      nsq_q;
	logic [BIN_W-1:0]                bin_q;
	logic [COORD_BITS-1:0]           ct_q, cx_q, cy_q, cz_q;
	logic [prcs_pkg::SAMPLE_W-1:0]   sample_q;
	logic                            last_q;
	logic                            m_tvalid_q;
	logic [prcs_pkg::RADIUS_W-1:0]   radius_q;
	logic [prcs_pkg::SUM_W-1:0]      sum_out_q;
	logic                            last_bin_q;

	// bin memory, valid bits and write stage
	logic [prcs_pkg::SUM_W-1:0] mem [MAX_BINS];
	logic [prcs_pkg::SUM_W-1:0] rd_data_q;
	logic                       rd_vld_q;
	logic [MAX_BINS-1:0]        vld_q;
	logic                       wr_s1;
	logic [BIN_W-1:0]           wr_addr_s1;

	// apb access
	logic       cfg_wr;
	logic [2:0] cfg_idx;
	assign pready  = 1'b1;
	assign cfg_idx = paddr[4:2];
	assign cfg_wr  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			extent_t_q   <= prcs_pkg::EXTENT_RST;
			extent_x_q   <= prcs_pkg::EXTENT_RST;
			extent_y_q   <= prcs_pkg::EXTENT_RST;
			extent_z_q   <= prcs_pkg::EXTENT_RST;
			mode_3d_q    <= 1'b0;
			max_radius_q <= prcs_pkg::MAX_RADIUS_RST;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				prcs_pkg::REG_EXTENT_T:   extent_t_q   <= pwdata[prcs_pkg::EXT_W-1:0];
				prcs_pkg::REG_EXTENT_X:   extent_x_q   <= pwdata[prcs_pkg::EXT_W-1:0];
				prcs_pkg::REG_EXTENT_Y:   extent_y_q   <= pwdata[prcs_pkg::EXT_W-1:0];
				prcs_pkg::REG_EXTENT_Z:   extent_z_q   <= pwdata[prcs_pkg::EXT_W-1:0];
				prcs_pkg::REG_MODE_3D:    mode_3d_q    <= pwdata[0];
				prcs_pkg::REG_MAX_RADIUS: max_radius_q <= pwdata[prcs_pkg::RADIUS_W-1:0];
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		prdata = '0;
		unique case (cfg_idx)
			prcs_pkg::REG_EXTENT_T:   prdata = prcs_pkg::APB_DATA_W'(extent_t_q);
			prcs_pkg::REG_EXTENT_X:   prdata = prcs_pkg::APB_DATA_W'(extent_x_q);
			prcs_pkg::REG_EXTENT_Y:   prdata = prcs_pkg::APB_DATA_W'(extent_y_q);
			prcs_pkg::REG_EXTENT_Z:   prdata = prcs_pkg::APB_DATA_W'(extent_z_q);
			prcs_pkg::REG_MODE_3D:    prdata = prcs_pkg::APB_DATA_W'(mode_3d_q);
			prcs_pkg::REG_MAX_RADIUS: prdata = prcs_pkg::APB_DATA_W'(max_radius_q);
			default:                  prdata = '0;
		endcase
	end

	// current axis coordinate and period, zero extent means 512
	logic [COORD_BITS-1:0]      coord_cur;
	logic [prcs_pkg::EXT_W-1:0] ext_cur;
	logic [prcs_pkg::DIV_W-1:0] n_cur;
	always_comb begin
		case (axis_q)
			prcs_pkg::AXIS_T: begin coord_cur = ct_q; ext_cur = extent_t_q; end
			prcs_pkg::AXIS_X: begin coord_cur = cx_q; ext_cur = extent_x_q; end
			prcs_pkg::AXIS_Y: begin coord_cur = cy_q; ext_cur = extent_y_q; end
			default:          begin coord_cur = cz_q; ext_cur = extent_z_q; end
		endcase
		n_cur = (ext_cur == '0) ? EXT_ZERO_N : {1'b0, ext_cur};
	end

	// one restoring remainder step
	logic [prcs_pkg::DIV_W-1:0] rem_shift;
	logic [prcs_pkg::DIV_W-1:0] rem_next;
	assign rem_shift = {rem_q[prcs_pkg::DIV_W-2:0], coord_cur[bit_q]};
	assign rem_next  = (rem_shift >= n_cur) ? (rem_shift - n_cur) : rem_shift;

	// minimum image fold and square
	logic [prcs_pkg::DIV_W:0]       rem_dbl;
	logic [8:0]                     img;
	logic [prcs_pkg::AXIS_SQ_W-1:0] img_sq;
	logic [prcs_pkg::DIV_W-1:0]     img_neg;
	assign rem_dbl = {rem_q, 1'b0};
	assign img_neg = n_cur - rem_q;
	assign img     = (rem_dbl > {1'b0, n_cur}) ? img_neg[8:0] : rem_q[8:0];
	assign img_sq  = img * img;

	// bin threshold test
	logic [2*BIN_W-1:0] bin_sq;
	logic               bin_hit;
	assign bin_sq  = bin_q * bin_q;
	assign bin_hit = prcs_pkg::NSQ_W'(bin_sq) >= nsq_q;

	// last radius emitted
	logic [BIN_W-1:0] top_bin;
	assign top_bin = ({1'b0, max_radius_q} > TOP_LIMIT) ? BIN_LAST : max_radius_q[BIN_W-1:0];

	// bin read data, unwritten bins read as zero
	logic [prcs_pkg::SUM_W-1:0] bin_val;
	assign bin_val = rd_vld_q ? rd_data_q : '0;

	logic out_load;
	assign out_load = (state_q == S_EMIT_OUT) && (!m_tvalid_q || m_tready);

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			axis_q     <= prcs_pkg::AXIS_T;
			bit_q      <= '0;
			rem_q      <= '0;
			nsq_q      <= '0;
			bin_q      <= '0;
			ct_q       <= '0;
			cx_q       <= '0;
			cy_q       <= '0;
			cz_q       <= '0;
			sample_q   <= '0;
			last_q     <= 1'b0;
			m_tvalid_q <= 1'b0;
			radius_q   <= '0;
			sum_out_q  <= '0;
			last_bin_q <= 1'b0;
			wr_s1      <= 1'b0;
			wr_addr_s1 <= '0;
			vld_q      <= '0;
			rd_vld_q   <= 1'b0;
		end else begin
			rd_vld_q <= vld_q[bin_q];
			wr_s1    <= (state_q == S_SWEEP) && bin_hit;
			wr_addr_s1 <= bin_q;
			if (wr_s1) begin
				vld_q[wr_addr_s1] <= 1'b1;
			end
			if (m_tvalid_q && m_tready && !out_load) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						ct_q     <= s_tdata[COORD_BITS-1:0];
						cx_q     <= s_tdata[2*COORD_BITS-1:COORD_BITS];
						cy_q     <= s_tdata[3*COORD_BITS-1:2*COORD_BITS];
						cz_q     <= s_tdata[4*COORD_BITS-1:3*COORD_BITS];
						sample_q <= s_tdata[4*COORD_BITS+prcs_pkg::SAMPLE_W-1:4*COORD_BITS];
						last_q   <= s_tlast;
						axis_q   <= mode_3d_q ? prcs_pkg::AXIS_X : prcs_pkg::AXIS_T;
						bit_q    <= BIT_TOP;
						rem_q    <= '0;
						nsq_q    <= '0;
						state_q  <= S_DIV;
					end
				end
				S_DIV: begin
					rem_q <= rem_next;
					if (bit_q == '0) begin
						state_q <= S_FOLD;
					end else begin
						bit_q <= bit_q - 1'b1;
					end
				end
				S_FOLD: begin
					nsq_q <= nsq_q + prcs_pkg::NSQ_W'(img_sq);
					if (axis_q == prcs_pkg::AXIS_Z) begin
						bin_q   <= '0;
						state_q <= S_SWEEP;
					end else begin
						axis_q  <= axis_q + 1'b1;
						rem_q   <= '0;
						bit_q   <= BIT_TOP;
						state_q <= S_DIV;
					end
				end
				S_SWEEP: begin
					if (bin_q == BIN_LAST) begin
						state_q <= S_DRAIN;
					end else begin
						bin_q <= bin_q + 1'b1;
					end
				end
				S_DRAIN: begin
					bin_q   <= '0;
					state_q <= last_q ? S_EMIT_RD : S_IDLE;
				end
				S_EMIT_RD: begin
					state_q <= S_EMIT_OUT;
				end
				S_EMIT_OUT: begin
					if (out_load) begin
						m_tvalid_q <= 1'b1;
						radius_q   <= prcs_pkg::RADIUS_W'(bin_q);
						sum_out_q  <= bin_val;
						last_bin_q <= (bin_q == top_bin);
						if (bin_q == top_bin) begin
							vld_q   <= '0;
							state_q <= S_IDLE;
						end else begin
							bin_q   <= bin_q + 1'b1;
							state_q <= S_EMIT_RD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// bin memory, one read and one write port
	always_ff @(posedge clk) begin
		if (wr_s1) begin
			mem[wr_addr_s1] <= prcs_pkg::sat_add(bin_val, sample_q);
		end
		rd_data_q <= mem[bin_q];
	end

	// ports
	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tlast  = last_bin_q;
	assign m_tdata  = OUT_DATA_W'({sum_out_q, radius_q});

	// bin writes happen only right after sweep reads
	a_wr_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		wr_s1 |-> (state_q == S_SWEEP || state_q == S_DRAIN))
		else $error("bin write outside the sweep");

	// remainder unit leaves a value below the period
	a_rem_below: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FOLD) |-> (rem_q < n_cur))
		else $error("remainder not below the period");

	// the final result of an emit clears all bins and frees the input
	a_clear_after_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && bin_q == top_bin) |=> (vld_q == '0 && state_q == S_IDLE))
		else $error("bins not cleared after emit");

	// no new point while an emit is under way
	a_no_accept_in_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT_RD || state_q == S_EMIT_OUT) |-> !s_tready)
		else $error("input ready during emit");

endmodule

### tb/sv/periodic_radial_cumulative_sum_tb.sv
// Self-checking bench for periodic_radial_cumulative_sum: lattice points in, radius sums out.
// Holds its own radial histogram predictor and drives apb and both streams; needs prcs_pkg.
module periodic_radial_cumulative_sum_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int BINS           = 64;
	localparam int CBITS          = 8;
	localparam int IN_W           = ((4*CBITS + prcs_pkg::SAMPLE_W + 7) / 8) * 8;
	localparam int OUT_W          = ((prcs_pkg::RADIUS_W + prcs_pkg::SUM_W + 7) / 8) * 8;
	localparam int DRAIN_CYCLES   = 200;
	localparam int HOLD_CYCLES    = 800;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int PHASE_ITEMS    = 58;

	typedef struct packed {
		logic [CBITS-1:0]              ct;
		logic [CBITS-1:0]              cx;
		logic [CBITS-1:0]              cy;
		logic [CBITS-1:0]              cz;
		logic [prcs_pkg::SAMPLE_W-1:0] sample;
		bit                            last;
	} point_t;

	typedef struct packed {
		logic [prcs_pkg::RADIUS_W-1:0] radius;
		logic [prcs_pkg::SUM_W-1:0]    sum;
		bit                            last_bin;
	} radius_sum_t;

	// radial histogram predictor and the queue of sums it owes
	class radial_histogram;
		logic [prcs_pkg::EXT_W-1:0]    extent [4];
		bit                            skip_t;
		logic [prcs_pkg::RADIUS_W-1:0] top_radius;
		longint                        bin_sum [BINS];
		radius_sum_t                   owed_sums [$];
		int                            mismatches;
		int                            points;
		int                            frames;
		int                            sums_seen;

		function new();
			foreach (extent[i]) extent[i] = prcs_pkg::EXTENT_RST;
			skip_t = 1'b0;
			top_radius = prcs_pkg::MAX_RADIUS_RST;
			foreach (bin_sum[i]) bin_sum[i] = 0;
			mismatches = 0;
			points = 0;
			frames = 0;
			sums_seen = 0;
		endfunction

		function void set_reg(input logic [2:0] idx,
			input logic [prcs_pkg::APB_DATA_W-1:0] value);
			case (idx)
				prcs_pkg::REG_EXTENT_T, prcs_pkg::REG_EXTENT_X,
				prcs_pkg::REG_EXTENT_Y, prcs_pkg::REG_EXTENT_Z: begin
					extent[idx] = value[prcs_pkg::EXT_W-1:0];
				end
				prcs_pkg::REG_MODE_3D: begin
					skip_t = value[0];
				end
				prcs_pkg::REG_MAX_RADIUS: begin
					top_radius = value[prcs_pkg::RADIUS_W-1:0];
				end
				default: begin
				end
			endcase
		endfunction

		// minimum-image square along one axis, a zero extent means 512
		function int axis_square(input logic [CBITS-1:0] c,
			input logic [prcs_pkg::EXT_W-1:0] e);
			int n;
			int r;
			int a;
			n = (e == 0) ? 512 : int'(e);
			r = int'(c) % n;
			a = (2 * r > n) ? n - r : r;
			return a * a;
		endfunction

		function longint saturate(input longint acc, input longint v);
			longint r;
			r = acc + v;
			if (v > 0 && r < acc) r = {1'b0, {63{1'b1}}};
			if (v < 0 && r > acc) r = {1'b1, {63{1'b0}}};
			return r;
		endfunction

		function void add_point(input point_t p);
			int     nsq;
			int     top;
			longint v;
			radius_sum_t rs;
			nsq = 0;
			if (!skip_t) nsq += axis_square(p.ct, extent[0]);
			nsq += axis_square(p.cx, extent[1]);
			nsq += axis_square(p.cy, extent[2]);
			nsq += axis_square(p.cz, extent[3]);
			v = longint'($signed(p.sample));
			for (int d = 0; d < BINS; d++) begin
				if (d * d >= nsq) bin_sum[d] = saturate(bin_sum[d], v);
			end
			points++;
			// last point: owe one sum per radius, then start a fresh field
			if (p.last) begin
				top = (int'(top_radius) > BINS - 1) ? BINS - 1 : int'(top_radius);
				for (int d = 0; d <= top; d++) begin
					rs.radius = d[prcs_pkg::RADIUS_W-1:0];
					rs.sum = bin_sum[d];
					rs.last_bin = (d == top);
					owed_sums.push_back(rs);
				end
				foreach (bin_sum[i]) bin_sum[i] = 0;
				frames++;
			end
		endfunction

		task report(input string what);
			if (mismatches < 40) $display("[%0t] mismatch: %s", $realtime, what);
			mismatches++;
		endtask

		task match_sum(input logic [prcs_pkg::RADIUS_W-1:0] r,
			input logic [prcs_pkg::SUM_W-1:0] s, input logic l);
			radius_sum_t want;
			if (owed_sums.size() == 0) begin
				report($sformatf("unexpected sum item radius %0d sum %0d", r, $signed(s)));
				return;
			end
			want = owed_sums.pop_front();
			sums_seen++;
			if (r !== want.radius)
				report($sformatf("radius %0d, want %0d", r, want.radius));
			if (s !== want.sum)
				report($sformatf("radius %0d sum %0d, want %0d", want.radius, $signed(s),
					$signed(want.sum)));
			if (l !== want.last_bin)
				report($sformatf("radius %0d last_bin %0b, want %0b", want.radius, l,
					want.last_bin));
		endtask
	endclass

	logic                            clk;
	logic                            arst_n   = 1'b0;
	logic                            psel     = 1'b0;
	logic                            penable  = 1'b0;
	logic                            pwrite   = 1'b0;
	logic [prcs_pkg::APB_ADDR_W-1:0] paddr    = '0;
	logic [prcs_pkg::APB_DATA_W-1:0] pwdata   = '0;
	logic [prcs_pkg::APB_DATA_W-1:0] prdata;
	logic                            pready;
	logic                            s_tvalid = 1'b0;
	logic                            s_tready;
	logic [IN_W-1:0]                 s_tdata  = '0;
	logic                            s_tlast  = 1'b0;
	logic                            m_tvalid;
	logic                            m_tready = 1'b0;
	logic [OUT_W-1:0]                m_tdata;
	logic                            m_tlast;

	int tx_idle_pct  = 0;
	int rx_stall_pct = 0;
	int hold_request = 0;
	int settings     = 0;

	radial_histogram board = new();

	periodic_radial_cumulative_sum #(
		.MAX_BINS  (BINS),
		.COORD_BITS(CBITS)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),  // coord_t, coord_x, coord_y, coord_z, sample_value
		.s_tlast (s_tlast),  // last_item
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),  // radius, cumulative_sum
		.m_tlast (m_tlast)   // last_bin
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// apb write: setup phase, then access phase, then the bus goes quiet
	task automatic reg_write(input logic [2:0] idx,
		input logic [prcs_pkg::APB_DATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		board.set_reg(idx, value);
		@(posedge clk);
	endtask

	task automatic configure(input logic [prcs_pkg::APB_DATA_W-1:0] et,
		input logic [prcs_pkg::APB_DATA_W-1:0] ex,
		input logic [prcs_pkg::APB_DATA_W-1:0] ey,
		input logic [prcs_pkg::APB_DATA_W-1:0] ez,
		input logic [prcs_pkg::APB_DATA_W-1:0] m3,
		input logic [prcs_pkg::APB_DATA_W-1:0] mr);
		reg_write(prcs_pkg::REG_EXTENT_T, et);
		reg_write(prcs_pkg::REG_EXTENT_X, ex);
		reg_write(prcs_pkg::REG_EXTENT_Y, ey);
		reg_write(prcs_pkg::REG_EXTENT_Z, ez);
		reg_write(prcs_pkg::REG_MODE_3D, m3);
		reg_write(prcs_pkg::REG_MAX_RADIUS, mr);
		settings++;
	endtask

	// offer one point after a random gap, hold it until taken
	task automatic send_point(input point_t p);
		bit taken;
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {p.sample, p.cz, p.cy, p.cx, p.ct};
		s_tlast  <= p.last;
		do begin
			@(negedge clk);
			taken = s_tready;
			@(posedge clk);
		end while (!taken);
		board.add_point(p);
	endtask

	task automatic wait_all_sums();
		while (board.owed_sums.size() != 0) @(posedge clk);
	endtask

	// idle the block before touching registers
	task automatic settle();
		s_tvalid <= 1'b0;
		wait_all_sums();
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic point_t lattice_point(input int ct, input int cx, input int cy,
		input int cz, input logic [prcs_pkg::SAMPLE_W-1:0] sample, input bit last);
		point_t p;
		p.ct = ct[CBITS-1:0];
		p.cx = cx[CBITS-1:0];
		p.cy = cy[CBITS-1:0];
		p.cz = cz[CBITS-1:0];
		p.sample = sample;
		p.last = last;
		return p;
	endfunction

	function automatic logic [CBITS-1:0] random_coord(input logic [prcs_pkg::EXT_W-1:0] e,
		input bit in_range);
		if (in_range && e != 0 && e <= 256) return CBITS'($urandom_range(0, int'(e) - 1));
		return CBITS'($urandom_range(0, 255));
	endfunction

	function automatic logic [prcs_pkg::SAMPLE_W-1:0] random_sample();
		case ($urandom_range(0, 5))
			0: begin
				case ($urandom_range(0, 3))
					0: return 32'h7FFF_FFFF;
					1: return 32'h8000_0000;
					2: return 32'hFFFF_FFFF;
					default: return 32'h0000_0000;
				endcase
			end
			1, 2: return $urandom;
			default: return 32'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
		endcase
	endfunction

	// mostly coordinates inside the lattice, some wrapped ones
	function automatic point_t random_point(input bit last);
		point_t p;
		bit in_range;
		in_range = ($urandom_range(0, 99) < 85);
		p.ct = random_coord(board.extent[0], in_range);
		p.cx = random_coord(board.extent[1], in_range);
		p.cy = random_coord(board.extent[2], in_range);
		p.cz = random_coord(board.extent[3], in_range);
		p.sample = random_sample();
		p.last = last;
		return p;
	endfunction

	function automatic logic [prcs_pkg::APB_DATA_W-1:0] random_extent();
		logic [prcs_pkg::APB_DATA_W-1:0] e;
		case ($urandom_range(0, 9))
			0: e = 1;
			1: e = 256;
			2: e = 0;
			3: e = $urandom_range(1, 256);
			default: e = $urandom_range(2, 20);
		endcase
		// junk above the field must be dropped
		if ($urandom_range(0, 3) == 0) e |= $urandom << prcs_pkg::EXT_W;
		return e;
	endfunction

	function automatic logic [prcs_pkg::APB_DATA_W-1:0] random_radius();
		case ($urandom_range(0, 4))
			0: return 0;
			1: return BINS - 1;
			default: return $urandom_range(0, BINS - 1);
		endcase
	endfunction

	// one random phase: fields of a few points each under a fresh setting
	task automatic random_phase(input int idle, input int stall, input bit with_hold);
		int sent;
		int len;
		int frame_no;
		tx_idle_pct  <= idle;
		rx_stall_pct <= stall;
		configure(random_extent(), random_extent(), random_extent(), random_extent(),
			$urandom_range(0, 1), random_radius());
		sent = 0;
		frame_no = 0;
		while (sent < PHASE_ITEMS) begin
			len = $urandom_range(1, 10);
			if (PHASE_ITEMS - sent < len) len = PHASE_ITEMS - sent;
			for (int k = 0; k < len; k++) begin
				send_point(random_point(k == len - 1));
				sent++;
			end
			// long receiver hold while the next field keeps coming
			if (with_hold && frame_no == 1) begin
				hold_request <= hold_request + 1;
			end else if ($urandom_range(0, 3) == 0) begin
				s_tvalid <= 1'b0;
				wait_all_sums();
			end
			frame_no++;
		end
		settle();
	endtask

	// result side: random stalls, long holds on request, checks each item
	initial begin : sum_sink
		int hold_left;
		int hold_served;
		hold_left = 0;
		hold_served = 0;
		forever begin
			@(posedge clk);
			if (hold_request != hold_served) begin
				hold_served = hold_request;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
			end
			@(negedge clk);
			if (m_tvalid && m_tready)
				board.match_sum(m_tdata[prcs_pkg::RADIUS_W-1:0],
					m_tdata[prcs_pkg::RADIUS_W +: prcs_pkg::SUM_W], m_tlast);
		end
	end

	// watchdog on cycles without any accepted item or register access
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(negedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) quiet = 0;
			else quiet++;
		end
		$display("[%0t] no progress for %0d cycles", $realtime, WATCHDOG_LIMIT);
		$display("periodic_radial_cumulative_sum_tb: errors");
		$finish;
	end

	initial begin : stimulus
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset setting: origin, half-lattice corner, wrapped coordinates
		send_point(lattice_point(0, 0, 0, 0, 32'h7FFF_FFFF, 1'b0));
		send_point(lattice_point(8, 8, 8, 8, 32'h8000_0000, 1'b0));
		send_point(lattice_point(15, 1, 9, 7, 32'hFFFF_FFFF, 1'b0));
		send_point(lattice_point(255, 200, 17, 33, 32'h0001_0000, 1'b0));
		send_point(lattice_point(1, 0, 0, 0, 32'h1234_5678, 1'b1));
		send_point(lattice_point(0, 0, 0, 0, 32'h0000_0005, 1'b1));
		settle();

		// smallest extent and extent 256, 3d norm, all radii
		configure(256, 1, 256, 1, 1, BINS - 1);
		send_point(lattice_point(128, 0, 128, 0, 32'h0003_0000, 1'b0));
		send_point(lattice_point(200, 255, 3, 77, 32'hFFFE_8000, 1'b0));
		send_point(lattice_point(255, 255, 255, 255, 32'hFFFF_FFFF, 1'b0));
		send_point(lattice_point(0, 0, 63, 0, 32'h7FFF_FFFF, 1'b1));
		settle();

		// zero extent reads as 512, single radius
		configure(0, 0, 0, 0, 0, 0);
		send_point(lattice_point(255, 255, 255, 255, 32'h0000_1000, 1'b0));
		send_point(lattice_point(0, 0, 0, 0, 32'h4000_0000, 1'b1));
		settle();

		// odd and even small extents
		configure(3, 5, 7, 2, 0, 31);
		send_point(lattice_point(2, 4, 6, 1, 32'h0001_8000, 1'b0));
		send_point(lattice_point(1, 1, 1, 1, 32'hFFFF_0000, 1'b0));
		send_point(lattice_point(0, 3, 4, 0, 32'h0000_0001, 1'b1));
		settle();

		random_phase(0, 0, 1'b1);
		random_phase(76, 0, 1'b0);
		random_phase(0, 76, 1'b0);
		random_phase(27, 27, 1'b1);

		wait_all_sums();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered %0d points in %0d fields, %0d radius sums compared",
			board.points, board.frames, board.sums_seen);
		$display("across %0d register settings, idle and stall mixes and long output holds",
			settings);
		if (board.mismatches == 0 && board.owed_sums.size() == 0) begin
			$display("periodic_radial_cumulative_sum_tb: clean");
		end else begin
			$display("periodic_radial_cumulative_sum_tb: errors");
		end
		$finish;
	end

endmodule

### sim.f
sv/prcs_pkg.sv
sv/periodic_radial_cumulative_sum.sv
tb/sv/periodic_radial_cumulative_sum_tb.sv
